/* hdl/bmic_pkg.sv */
`default_nettype none

package bmic_pkg;

   // input kinds
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // bytes of interest
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_LCURLY  = 8'h7b;
   localparam logic [7:0] CHAR_RCURLY  = 8'h7d;
   localparam logic [7:0] CHAR_LSQUARE = 8'h5b;
   localparam logic [7:0] CHAR_RSQUARE = 8'h5d;

   // bracket kinds
   localparam logic [1:0] TYPE_ROUND  = 2'd0;
   localparam logic [1:0] TYPE_CURLY  = 2'd1;
   localparam logic [1:0] TYPE_SQUARE = 2'd2;

   // report kinds
   localparam logic [1:0] RPT_INTERLOCK = 2'd0;
   localparam logic [1:0] RPT_OVERFLOW  = 2'd1;
   localparam logic [1:0] RPT_SUMMARY   = 2'd2;

   localparam int LINE_FIELD_BITS   = 24;
   localparam int COLUMN_FIELD_BITS = 16;
   localparam int TOTAL_FIELD_BITS  = 12;
   localparam logic [TOTAL_FIELD_BITS-1:0] TOTAL_MAX = 12'd4095;
   localparam int RSP_TDATA_BITS = 112;

   typedef struct packed {
      logic                         last_of_run;
      logic [1:0]                   report_kind;
      logic [LINE_FIELD_BITS-1:0]   other_line;
      logic [COLUMN_FIELD_BITS-1:0] other_column;
      logic [LINE_FIELD_BITS-1:0]   this_line;
      logic [COLUMN_FIELD_BITS-1:0] this_column;
      logic [1:0]                   other_type;
      logic [1:0]                   this_type;
      logic [TOTAL_FIELD_BITS-1:0]  unmatched_open_total;
      logic [TOTAL_FIELD_BITS-1:0]  unmatched_close_total;
      logic                         all_clear;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/bmic_stack_mem.sv */
`default_nettype none

module bmic_stack_mem #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 40,
   parameter int ENTRIES   = 3072
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] entries_ff [ENTRIES];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/bmic_rsp_fifo.sv */
`default_nettype none

module bmic_rsp_fifo
   import bmic_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] wr_count,
   input  wire rsp_type    wr_rec0,
   input  wire rsp_type    wr_rec1,
   output logic            has_room,
   output logic            out_valid,
   output rsp_type         out_rec,
   input  wire logic       out_ready
);

   localparam int DEPTH      = 4;
   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   rsp_type                entries_ff [DEPTH];
   logic [PTR_BITS-1:0]    wptr_ff, wptr_in;
   logic [PTR_BITS-1:0]    rptr_ff, rptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_rec   = entries_ff[rptr_ff];
   assign pop       = out_valid && out_ready;
   // room for the largest burst one item can cause
   assign has_room  = (count_ff <= COUNT_BITS'(DEPTH - 2));

   always_comb begin
      wptr_in  = wptr_ff + PTR_BITS'(wr_count);
      rptr_in  = rptr_ff + PTR_BITS'(pop);
      count_in = count_ff + COUNT_BITS'(wr_count) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         entries_ff[wptr_ff] <= wr_rec0;
      end
      if (wr_count == 2'd2) begin
         entries_ff[wptr_ff + PTR_BITS'(1)] <= wr_rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/bracket_match_interlock_checker_core.sv */
`default_nettype none

// Bracket match and interlock checker.
// req channel: one transfer per text byte (req_tuser = 0) or end of stream (req_tuser = 1).
// rsp channel: interlock, overflow and summary reports, rsp_tlast on the last report of a
//    transfer. Most bytes cause no report at all.
// Throughput: one byte per cycle while the output queue has room, except a closing
//    bracket that pops a stack leaving it non-empty: the new stack top is then read back
//    from the position memory into the top-of-stack register before the next byte.
// A report can leave on rsp in the cycle after its byte is taken (the engine decides
//    in the accepting cycle and writes a four-entry output queue).
// The top of every stack lives in a register; older entries live in one shared memory
//    addressed by {bracket kind, depth}.
// Reset clears depths, counters and flags at once; the memory needs no clearing pass.
// End of stream emits a summary and returns to the reset state.
// When rsp stalls the output queue absorbs reports; req_tready drops once fewer than two
//    queue entries are free.
module bracket_match_interlock_checker_core
   import bmic_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int LINE_BITS   = 24,
   parameter int COLUMN_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,  // text_byte
   input  wire logic                      req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // other_line, other_column, this_line, this_column, other_type, this_type,
   // unmatched_open_total, unmatched_close_total, all_clear, zero pad
   output logic [RSP_TDATA_BITS-1:0]      rsp_tdata,
   output logic [1:0]                     rsp_tuser,  // report_kind
   output logic                           rsp_tlast   // last_of_run
);

   localparam int IDX_BITS    = $clog2(STACK_DEPTH);
   localparam int DEPTH_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int POS_BITS    = LINE_BITS + COLUMN_BITS;
   localparam int ADDR_BITS   = IDX_BITS + 2;
   localparam int MEM_ENTRIES = 3 * (2 ** IDX_BITS);
   localparam int SUM_BITS    = DEPTH_BITS + 2;
   localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = DEPTH_BITS'(STACK_DEPTH);

   function automatic logic [LINE_FIELD_BITS-1:0] line_field(input logic [LINE_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[LINE_FIELD_BITS-1:0];
   endfunction

   function automatic logic [COLUMN_FIELD_BITS-1:0] col_field(
      input logic [COLUMN_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[COLUMN_FIELD_BITS-1:0];
   endfunction

   function automatic logic [TOTAL_FIELD_BITS-1:0] total_field(input logic [SUM_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'(TOTAL_MAX)) ? TOTAL_MAX : w[TOTAL_FIELD_BITS-1:0];
   endfunction

   // state
   logic [DEPTH_BITS-1:0]  depth_ff [3];
   logic [DEPTH_BITS-1:0]  depth_in [3];
   logic [DEPTH_BITS-1:0]  close_cnt_ff [3];
   logic [DEPTH_BITS-1:0]  close_cnt_in [3];
   logic [POS_BITS-1:0]    top_ff [3];
   logic [POS_BITS-1:0]    top_in [3];
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic                   interlock_ff, interlock_in;
   logic                   halted_ff, halted_in;
   logic                   refill_ff, refill_in;
   logic [1:0]             refill_type_ff, refill_type_in;

   // memory port
   logic                   mem_we, mem_re;
   logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
   logic [POS_BITS-1:0]    mem_wdata, mem_rdata;

   // output queue
   logic [1:0]             wr_count;
   rsp_type                rec0, rec1, out_rec;
   logic                   has_room;

   logic                   accept;
   logic [COLUMN_BITS-1:0] col_next;
   logic                   is_bracket, is_open;
   logic [1:0]             t, k1, k2;
   logic                   hit1, hit2;
   logic [SUM_BITS-1:0]    open_sum, close_sum;
   logic [POS_BITS-1:0]    pos_now;
   rsp_type                rpt1, rpt2;

   assign req_tready = has_room && !refill_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      is_bracket = 1'b1;
      is_open    = 1'b1;
      t          = TYPE_ROUND;
      case (req_tdata)
         CHAR_LPAREN: begin
            t = TYPE_ROUND;
         end
         CHAR_RPAREN: begin
            t       = TYPE_ROUND;
            is_open = 1'b0;
         end
         CHAR_LCURLY: begin
            t = TYPE_CURLY;
         end
         CHAR_RCURLY: begin
            t       = TYPE_CURLY;
            is_open = 1'b0;
         end
         CHAR_LSQUARE: begin
            t = TYPE_SQUARE;
         end
         CHAR_RSQUARE: begin
            t       = TYPE_SQUARE;
            is_open = 1'b0;
         end
         default: begin
            is_bracket = 1'b0;
         end
      endcase
   end

   // the other two kinds, in ascending order
   assign k1 = (t == TYPE_ROUND) ? TYPE_CURLY : TYPE_ROUND;
   assign k2 = (t == TYPE_SQUARE) ? TYPE_CURLY : TYPE_SQUARE;

   assign col_next = (col_ff != '1) ? col_ff + COLUMN_BITS'(1) : col_ff;
   assign pos_now  = {line_ff, col_next};

   // later-opened means a strictly greater {line, column}
   assign hit1 = (depth_ff[k1] != '0) && (top_ff[k1] > top_ff[t]);
   assign hit2 = (depth_ff[k2] != '0) && (top_ff[k2] > top_ff[t]);

   assign open_sum  = SUM_BITS'(depth_ff[0]) + SUM_BITS'(depth_ff[1])
                    + SUM_BITS'(depth_ff[2]);
   assign close_sum = SUM_BITS'(close_cnt_ff[0]) + SUM_BITS'(close_cnt_ff[1])
                    + SUM_BITS'(close_cnt_ff[2]);

   always_comb begin
      rpt1              = '0;
      rpt1.report_kind  = RPT_INTERLOCK;
      rpt1.other_line   = line_field(top_ff[k1][POS_BITS-1 -: LINE_BITS]);
      rpt1.other_column = col_field(top_ff[k1][COLUMN_BITS-1:0]);
      rpt1.this_line    = line_field(line_ff);
      rpt1.this_column  = col_field(col_next);
      rpt1.other_type   = k1;
      rpt1.this_type    = t;
      rpt2              = rpt1;
      rpt2.other_line   = line_field(top_ff[k2][POS_BITS-1 -: LINE_BITS]);
      rpt2.other_column = col_field(top_ff[k2][COLUMN_BITS-1:0]);
      rpt2.other_type   = k2;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         depth_in[i]     = depth_ff[i];
         close_cnt_in[i] = close_cnt_ff[i];
         top_in[i]       = top_ff[i];
      end
      line_in        = line_ff;
      col_in         = col_ff;
      interlock_in   = interlock_ff;
      halted_in      = halted_ff;
      refill_in      = 1'b0;
      refill_type_in = refill_type_ff;
      mem_we         = 1'b0;
      mem_waddr      = {t, depth_ff[t][IDX_BITS-1:0]};
      mem_wdata      = pos_now;
      mem_re         = 1'b0;
      mem_raddr      = {t, IDX_BITS'(depth_ff[t] - DEPTH_BITS'(2))};
      wr_count       = 2'd0;
      rec0           = '0;
      rec1           = '0;

      if (refill_ff) begin
         top_in[refill_type_ff] = mem_rdata;
      end

      if (accept) begin
         if (req_tuser == KIND_END) begin
            rec0.report_kind           = RPT_SUMMARY;
            rec0.unmatched_open_total  = total_field(open_sum);
            rec0.unmatched_close_total = total_field(close_sum);
            rec0.all_clear             = (open_sum == '0) && (close_sum == '0)
                                         && !interlock_ff;
            rec0.last_of_run           = 1'b1;
            wr_count                   = 2'd1;
            for (int i = 0; i < 3; i++) begin
               depth_in[i]     = '0;
               close_cnt_in[i] = '0;
            end
            line_in      = LINE_BITS'(1);
            col_in       = '0;
            interlock_in = 1'b0;
            halted_in    = 1'b0;
         end else if (!halted_ff) begin
            if (req_tdata == CHAR_NEWLINE) begin
               if (line_ff != '1) begin
                  line_in = line_ff + LINE_BITS'(1);
               end
               col_in = '0;
            end else begin
               col_in = col_next;
               if (is_bracket && is_open) begin
                  if (depth_ff[t] >= DEPTH_FULL) begin
                     rec0.report_kind = RPT_OVERFLOW;
                     rec0.this_line   = line_field(line_ff);
                     rec0.this_column = col_field(col_next);
                     rec0.this_type   = t;
                     rec0.last_of_run = 1'b1;
                     wr_count         = 2'd1;
                     halted_in        = 1'b1;
                  end else begin
                     mem_we      = 1'b1;
                     top_in[t]   = pos_now;
                     depth_in[t] = depth_ff[t] + DEPTH_BITS'(1);
                  end
               end else if (is_bracket) begin
                  if (depth_ff[t] == '0) begin
                     if (close_cnt_ff[t] < DEPTH_FULL) begin
                        close_cnt_in[t] = close_cnt_ff[t] + DEPTH_BITS'(1);
                     end
                  end else begin
                     depth_in[t] = depth_ff[t] - DEPTH_BITS'(1);
                     // fetch the entry below the popped top
                     if (depth_ff[t] >= DEPTH_BITS'(2)) begin
                        mem_re         = 1'b1;
                        refill_in      = 1'b1;
                        refill_type_in = t;
                     end
                     if (hit1 || hit2) begin
                        interlock_in = 1'b1;
                     end
                     if (hit1 && hit2) begin
                        rec0             = rpt1;
                        rec1             = rpt2;
                        rec1.last_of_run = 1'b1;
                        wr_count         = 2'd2;
                     end else if (hit1) begin
                        rec0             = rpt1;
                        rec0.last_of_run = 1'b1;
                        wr_count         = 2'd1;
                     end else if (hit2) begin
                        rec0             = rpt2;
                        rec0.last_of_run = 1'b1;
                        wr_count         = 2'd1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         top_ff[i] <= top_in[i];
      end
      refill_type_ff <= refill_type_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            depth_ff[i]     <= '0;
            close_cnt_ff[i] <= '0;
         end
         line_ff      <= LINE_BITS'(1);
         col_ff       <= '0;
         interlock_ff <= 1'b0;
         halted_ff    <= 1'b0;
         refill_ff    <= 1'b0;
      end else begin
         for (int i = 0; i < 3; i++) begin
            depth_ff[i]     <= depth_in[i];
            close_cnt_ff[i] <= close_cnt_in[i];
         end
         line_ff      <= line_in;
         col_ff       <= col_in;
         interlock_ff <= interlock_in;
         halted_ff    <= halted_in;
         refill_ff    <= refill_in;
      end
   end

   bmic_stack_mem #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (POS_BITS),
      .ENTRIES   (MEM_ENTRIES)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   bmic_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_count  (wr_count),
      .wr_rec0   (rec0),
      .wr_rec1   (rec1),
      .has_room  (has_room),
      .out_valid (rsp_tvalid),
      .out_rec   (out_rec),
      .out_ready (rsp_tready)
   );

   assign rsp_tuser = out_rec.report_kind;
   assign rsp_tlast = out_rec.last_of_run;
   assign rsp_tdata = {3'b000,
                       out_rec.all_clear,
                       out_rec.unmatched_close_total,
                       out_rec.unmatched_open_total,
                       out_rec.this_type,
                       out_rec.other_type,
                       out_rec.this_column,
                       out_rec.this_line,
                       out_rec.other_column,
                       out_rec.other_line};

   // no byte is taken while a stack top is being reloaded
   a_refill_blocks: assert property (@(posedge clock) disable iff (reset)
      refill_ff |-> !req_tready)
      else $error("byte accepted during stack top reload");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (depth_ff[0] <= DEPTH_FULL) && (depth_ff[1] <= DEPTH_FULL)
      && (depth_ff[2] <= DEPTH_FULL))
      else $error("stack depth beyond capacity");

   a_halted_frozen: assert property (@(posedge clock) disable iff (reset)
      (accept && halted_ff && req_tuser == KIND_TEXT)
      |=> ($stable(line_ff) && $stable(col_ff) && halted_ff))
      else $error("text byte changed state while halted");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == KIND_END)
      |=> (depth_ff[0] == '0 && depth_ff[1] == '0 && depth_ff[2] == '0
           && line_ff == LINE_BITS'(1) && !halted_ff && !interlock_ff))
      else $error("end of stream did not clear state");

endmodule

`default_nettype wire
